[rtl/tpgt_pkg.sv]
// shared types, constants and helpers of the triac phase gate timer
`timescale 1ns / 1ps
`default_nettype none
package tpgt_pkg;

	localparam int unsigned TIME_W   = 16;
	localparam int unsigned SUM_W    = 20;
	localparam int unsigned CNT_W    = 8;
	localparam int unsigned FRAC_W   = 8;
	localparam int unsigned PHASE_W  = 3;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 16;

	localparam int unsigned PERIOD_COUNT_DEF = 16;

	localparam logic [CNT_W-1:0]  SETTLE_RST      = 8'd30;
	localparam logic [TIME_W-1:0] PULSE_WIDTH_RST = 16'd1000;
	localparam logic [TIME_W-1:0] PRE_ZERO_RST    = 16'd500;
	localparam logic [TIME_W-1:0] SAFE_DELAY_RST  = 16'd100;
	localparam logic [FRAC_W-1:0] FRACTION_RST    = 8'd218;
	localparam logic [TIME_W-1:0] GATE_DELAY_RST  = 16'd1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SETTLE_EVENTS  = 3'd0,
		CFG_PULSE_WIDTH    = 3'd1,
		CFG_PRE_ZERO       = 3'd2,
		CFG_SAFE_DELAY     = 3'd3,
		CFG_FRACTION       = 3'd4
	} cfg_idx_t;

	typedef enum logic [4:0] {
		SYNC_SETTLE  = 5'b00001,
		SYNC_FIRST   = 5'b00010,
		SYNC_MEASURE = 5'b00100,
		SYNC_ARM     = 5'b01000,
		SYNC_RUN     = 5'b10000
	} sync_stage_t;

	typedef enum logic [4:0] {
		G_FIRST_ON   = 5'b00001,
		G_FIRST_OFF  = 5'b00010,
		G_SECOND_ON  = 5'b00100,
		G_SECOND_OFF = 5'b01000,
		G_SAFE       = 5'b10000
	} gate_stage_t;

	localparam logic [PHASE_W-1:0] PHASE_SETTLE  = 3'd0;
	localparam logic [PHASE_W-1:0] PHASE_FIRST   = 3'd1;
	localparam logic [PHASE_W-1:0] PHASE_MEASURE = 3'd2;
	localparam logic [PHASE_W-1:0] PHASE_ARM     = 3'd3;
	localparam logic [PHASE_W-1:0] PHASE_RUN     = 3'd4;

	typedef struct packed {
		logic [CNT_W-1:0]  settle_events;
		logic [TIME_W-1:0] gate_pulse_width;
		logic [TIME_W-1:0] pre_zero_offset;
		logic [TIME_W-1:0] safe_release_delay;
		logic [FRAC_W-1:0] usable_fraction;
	} cfg_t;

	typedef struct packed {
		logic              zero_cross_event;
		logic              compare_event;
		logic [TIME_W-1:0] capture_time;
	} item_t;

	typedef struct packed {
		logic               pin_level;
		logic               pin_written;
		logic [TIME_W-1:0]  compare_time;
		logic               compare_written;
		logic               gate_pulse_started;
		logic [TIME_W-1:0]  measured_half_period;
		logic [PHASE_W-1:0] sync_phase;
	} result_t;

	function automatic logic [PHASE_W-1:0] phase_code(input sync_stage_t st);
		logic [PHASE_W-1:0] code;
		code = PHASE_SETTLE;
		unique case (st)
			SYNC_SETTLE:  code = PHASE_SETTLE;
			SYNC_FIRST:   code = PHASE_FIRST;
			SYNC_MEASURE: code = PHASE_MEASURE;
			SYNC_ARM:     code = PHASE_ARM;
			SYNC_RUN:     code = PHASE_RUN;
			default:      code = PHASE_SETTLE;
		endcase
		return code;
	endfunction

endpackage
`default_nettype wire

[rtl/triac_phase_gate_timer.sv]
// top level of the triac phase gate timer: input register, engine, result register
`timescale 1ns / 1ps
`default_nettype none
// Phase-angle gate timer for a triac, synchronised to the line zero crossing.
// Each input beat is one timer event (zero-cross capture, compare match or
// both) and yields exactly one result beat. The block takes one event per
// clock while out_stall is low; a beat goes through an input register,
// the update logic and a result register, which presents its result.
// The input register lets a new event in while a finished result waits
// at the output. The gate delay (half period times usable_fraction / 256)
// comes from a multiplier on the registered half period: the event right
// after the measurement reads the product directly and the delay register
// takes it in the cycle after the measurement. Configuration registers
// are written through cfg_we / cfg_index / cfg_data and should only change
// while no event is in flight.
module triac_phase_gate_timer #(
	parameter int unsigned PERIOD_COUNT = tpgt_pkg::PERIOD_COUNT_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [tpgt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [tpgt_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              zero_cross_event,
	input  wire logic                              compare_event,
	input  wire logic [tpgt_pkg::TIME_W-1:0]       capture_time,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic                                   pin_level,
	output logic                                   pin_written,
	output logic [tpgt_pkg::TIME_W-1:0]            compare_time,
	output logic                                   compare_written,
	output logic                                   gate_pulse_started,
	output logic [tpgt_pkg::TIME_W-1:0]            measured_half_period,
	output logic [tpgt_pkg::PHASE_W-1:0]           sync_phase
);
	import tpgt_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_q;
	logic    out_valid_q;
	logic    advance;
	logic    step;
	logic    in_take;

	tpgt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// result register is free or being drained this cycle
	assign advance  = !out_valid_q || !out_stall;
	assign step     = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1.zero_cross_event <= zero_cross_event;
			item_s1.compare_event    <= compare_event;
			item_s1.capture_time     <= capture_time;
		end
		if (step) begin
			res_q <= res;
		end
	end

	tpgt_engine #(
		.PERIOD_COUNT (PERIOD_COUNT)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign out_valid            = out_valid_q;
	assign pin_level            = res_q.pin_level;
	assign pin_written          = res_q.pin_written;
	assign compare_time         = res_q.compare_time;
	assign compare_written      = res_q.compare_written;
	assign gate_pulse_started   = res_q.gate_pulse_started;
	assign measured_half_period = res_q.measured_half_period;
	assign sync_phase           = res_q.sync_phase;

`ifndef SYNTHESIS
	a_stall_needs_beat: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without a held beat");

	a_step_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid)
		else $error("engine step did not produce a result beat");

	a_fire_has_compare: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && pin_written && !pin_level) |-> (compare_written && gate_pulse_started))
		else $error("gate firing without compare reload");

	a_fire_when_armed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && gate_pulse_started) |-> (sync_phase == PHASE_ARM || sync_phase == PHASE_RUN))
		else $error("gate pulse before arming");
`endif

endmodule
`default_nettype wire

[rtl/tpgt_cfg.sv]
// configuration register file of the triac phase gate timer
`timescale 1ns / 1ps
`default_nettype none
module tpgt_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [tpgt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [tpgt_pkg::CFG_DATA_W-1:0]   cfg_data,
	output tpgt_pkg::cfg_t                         cfg
);
	import tpgt_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_events      <= SETTLE_RST;
			cfg_q.gate_pulse_width   <= PULSE_WIDTH_RST;
			cfg_q.pre_zero_offset    <= PRE_ZERO_RST;
			cfg_q.safe_release_delay <= SAFE_DELAY_RST;
			cfg_q.usable_fraction    <= FRACTION_RST;
		end else if (cfg_we) begin
			// indexes past the list are dropped
			unique case (cfg_idx_t'(cfg_index))
				CFG_SETTLE_EVENTS: cfg_q.settle_events      <= cfg_data[CNT_W-1:0];
				CFG_PULSE_WIDTH:   cfg_q.gate_pulse_width   <= cfg_data[TIME_W-1:0];
				CFG_PRE_ZERO:      cfg_q.pre_zero_offset    <= cfg_data[TIME_W-1:0];
				CFG_SAFE_DELAY:    cfg_q.safe_release_delay <= cfg_data[TIME_W-1:0];
				CFG_FRACTION:      cfg_q.usable_fraction    <= cfg_data[FRAC_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

[rtl/tpgt_engine.sv]
// sync and gate scheduling state with the per-event update logic
`timescale 1ns / 1ps
`default_nettype none
module tpgt_engine #(
	parameter int unsigned PERIOD_COUNT = tpgt_pkg::PERIOD_COUNT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire tpgt_pkg::item_t   item,
	input  wire tpgt_pkg::cfg_t    cfg,
	output tpgt_pkg::result_t      res
);
	import tpgt_pkg::*;

	// half period = sum / (2 * count), done as multiply by a rounded-up reciprocal
	localparam int unsigned DIVISOR = 2 * PERIOD_COUNT;
	localparam int unsigned SHIFT   = SUM_W + $clog2(DIVISOR);
	localparam int unsigned RECIP_W = SUM_W + 1;
	localparam int unsigned PROD_W  = SUM_W + RECIP_W;
	localparam longint unsigned RECIP = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;

	sync_stage_t       sync_q, sync_n;
	gate_stage_t       gate_q, gate_n;
	logic [CNT_W-1:0]  cnt_q, cnt_n, cnt_inc;
	logic [TIME_W-1:0] last_q, last_n;
	logic [SUM_W-1:0]  sum_q, sum_n;
	logic [TIME_W-1:0] half_q, half_n;
	logic [TIME_W-1:0] gd_q;
	logic [TIME_W-1:0] gd_cur;
	logic [TIME_W-1:0] interval;
	logic [TIME_W-1:0] sched_q, sched_n;
	logic              pin_q, pin_n;
	logic              gd_pend_q, gd_pend_n;
	logic              pin_w, cmp_w, started;

	logic [PROD_W-1:0]        div_prod;
	logic [PROD_W-1:0]        div_quo;
	logic [TIME_W+FRAC_W-1:0] gd_prod;

	assign cnt_inc  = cnt_q + 1'b1;
	// capture interval wraps at the timer width
	assign interval = item.capture_time - last_q;

	always_comb begin
		sync_n    = sync_q;
		gate_n    = gate_q;
		cnt_n     = cnt_q;
		last_n    = last_q;
		sum_n     = sum_q;
		half_n    = half_q;
		sched_n   = sched_q;
		pin_n     = pin_q;
		gd_pend_n = 1'b0;
		pin_w     = 1'b0;
		cmp_w     = 1'b0;
		started   = 1'b0;
		div_prod  = '0;
		div_quo   = '0;

		if (item.zero_cross_event) begin
			unique case (sync_q)
				SYNC_SETTLE: begin
					if (cnt_inc == cfg.settle_events) begin
						cnt_n  = '0;
						sync_n = SYNC_FIRST;
					end else begin
						cnt_n = cnt_inc;
					end
				end
				SYNC_FIRST: begin
					last_n = item.capture_time;
					cnt_n  = '0;
					sum_n  = '0;
					sync_n = SYNC_MEASURE;
				end
				SYNC_MEASURE: begin
					sum_n  = sum_q + SUM_W'(interval);
					last_n = item.capture_time;
					cnt_n  = cnt_inc;
					if (cnt_inc == CNT_W'(PERIOD_COUNT)) begin
						div_prod  = PROD_W'(sum_n) * PROD_W'(RECIP_W'(RECIP));
						div_quo   = div_prod >> SHIFT;
						half_n    = div_quo[TIME_W-1:0];
						gd_pend_n = 1'b1;
						sync_n    = SYNC_ARM;
					end
				end
				SYNC_ARM: begin
					last_n  = item.capture_time;
					sched_n = item.capture_time + half_q - cfg.pre_zero_offset;
					cmp_w   = 1'b1;
					gate_n  = G_SAFE;
					sync_n  = SYNC_RUN;
				end
				SYNC_RUN: begin
					last_n  = item.capture_time;
					sched_n = item.capture_time + gd_cur;
					cmp_w   = 1'b1;
					gate_n  = G_FIRST_ON;
				end
				default: ;
			endcase
		end

		if (item.compare_event && (sync_n == SYNC_ARM || sync_n == SYNC_RUN)) begin
			unique case (gate_n)
				G_FIRST_ON, G_SECOND_ON: begin
					pin_n   = 1'b0;
					pin_w   = 1'b1;
					started = 1'b1;
					sched_n = sched_n + cfg.gate_pulse_width;
					cmp_w   = 1'b1;
					gate_n  = (gate_n == G_FIRST_ON) ? G_FIRST_OFF : G_SECOND_OFF;
				end
				G_FIRST_OFF: begin
					pin_n   = 1'b1;
					pin_w   = 1'b1;
					sched_n = last_n + half_n + gd_cur;
					cmp_w   = 1'b1;
					gate_n  = G_SECOND_ON;
				end
				G_SECOND_OFF: begin
					pin_n  = 1'b1;
					pin_w  = 1'b1;
					gate_n = G_FIRST_ON;
				end
				G_SAFE: begin
					pin_n   = 1'b1;
					pin_w   = 1'b1;
					sched_n = sched_n + cfg.safe_release_delay;
					cmp_w   = 1'b1;
					gate_n  = G_FIRST_OFF;
				end
				default: ;
			endcase
		end
	end

	// gate delay register is loaded in the cycle after the half period; the event right
	// after the measurement reads the product directly
	assign gd_prod = {{FRAC_W{1'b0}}, half_q} * {{TIME_W{1'b0}}, cfg.usable_fraction};
	assign gd_cur  = gd_pend_q ? gd_prod[FRAC_W +: TIME_W] : gd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q    <= SYNC_SETTLE;
			gate_q    <= G_SAFE;
			cnt_q     <= '0;
			last_q    <= '0;
			sum_q     <= '0;
			half_q    <= '0;
			gd_q      <= GATE_DELAY_RST;
			sched_q   <= '0;
			pin_q     <= 1'b0;
			gd_pend_q <= 1'b0;
		end else begin
			gd_pend_q <= step & gd_pend_n;
			if (gd_pend_q) begin
				gd_q <= gd_prod[FRAC_W +: TIME_W];
			end
			if (step) begin
				sync_q  <= sync_n;
				gate_q  <= gate_n;
				cnt_q   <= cnt_n;
				last_q  <= last_n;
				sum_q   <= sum_n;
				half_q  <= half_n;
				sched_q <= sched_n;
				pin_q   <= pin_n;
			end
		end
	end

	always_comb begin
		res.pin_level            = pin_n;
		res.pin_written          = pin_w;
		res.compare_time         = cmp_w ? sched_n : '0;
		res.compare_written      = cmp_w;
		res.gate_pulse_started   = started;
		res.measured_half_period = half_n;
		res.sync_phase           = phase_code(sync_n);
	end

endmodule
`default_nettype wire

[tb/sv/tb.sv]
// testbench of the triac phase gate timer: directed table, random line traffic, predictor
`timescale 1ns / 1ps
module tb;
	import tpgt_pkg::*;

	localparam int unsigned MEAS_CROSSINGS = PERIOD_COUNT_DEF;
	localparam int unsigned PHASE_ITEMS    = 292;

	typedef struct packed {
		logic [8:0]        reps;
		logic              zc;
		logic              cmp;
		logic [TIME_W-1:0] cap;
		logic              typed;
		result_t           want;
	} script_row_t;

	// outcomes that need no arithmetic: nothing happens while settling
	localparam result_t AT_REST       = '0;
	localparam result_t SETTLED       = '{sync_phase: PHASE_FIRST, default: '0};
	localparam result_t MEASURE_START = '{sync_phase: PHASE_MEASURE, default: '0};

	localparam script_row_t SCRIPT [25] = '{
		'{9'd1,   1'b0, 1'b1, 16'hFFFF, 1'b1, AT_REST},
		'{9'd1,   1'b0, 1'b0, 16'h0000, 1'b1, AT_REST},
		'{9'd254, 1'b1, 1'b0, 16'h1234, 1'b1, AT_REST},
		'{9'd1,   1'b1, 1'b1, 16'h0000, 1'b1, AT_REST},
		// 256th crossing: the 8-bit settle counter wraps onto a setting of zero
		'{9'd1,   1'b1, 1'b0, 16'hFFFF, 1'b1, SETTLED},
		'{9'd1,   1'b1, 1'b1, 16'hFFF0, 1'b1, MEASURE_START},
		'{9'd1,   1'b1, 1'b0, 16'hFFEF, 1'b0, '0},
		'{9'd1,   1'b1, 1'b1, 16'hFFEE, 1'b0, '0},
		'{9'd1,   1'b1, 1'b0, 16'h0000, 1'b0, '0},
		'{9'd1,   1'b1, 1'b0, 16'h8000, 1'b0, '0},
		'{9'd11,  1'b1, 1'b0, 16'h8000, 1'b0, '0},
		// last measuring crossing, compare lands in arming with the safe gate stage
		'{9'd1,   1'b1, 1'b1, 16'h4E20, 1'b0, '0},
		'{9'd1,   1'b1, 1'b0, 16'h1000, 1'b0, '0},
		'{9'd1,   1'b0, 1'b1, 16'h0000, 1'b0, '0},
		'{9'd1,   1'b0, 1'b1, 16'h5555, 1'b0, '0},
		'{9'd1,   1'b0, 1'b1, 16'hAAAA, 1'b0, '0},
		'{9'd1,   1'b0, 1'b1, 16'h0000, 1'b0, '0},
		'{9'd1,   1'b1, 1'b0, 16'h2000, 1'b0, '0},
		'{9'd1,   1'b1, 1'b1, 16'h3000, 1'b0, '0},
		'{9'd1,   1'b0, 1'b1, 16'h0000, 1'b0, '0},
		'{9'd1,   1'b0, 1'b0, 16'h7FFF, 1'b0, '0},
		'{9'd1,   1'b0, 1'b1, 16'h0000, 1'b0, '0},
		'{9'd1,   1'b1, 1'b0, 16'hFFFF, 1'b0, '0},
		'{9'd1,   1'b0, 1'b1, 16'h0000, 1'b0, '0},
		'{9'd1,   1'b0, 1'b1, 16'h0000, 1'b0, '0}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	logic                  zero_cross_event;
	logic                  compare_event;
	logic [TIME_W-1:0]     capture_time;
	logic                  out_valid;
	logic                  out_stall;
	logic                  pin_level;
	logic                  pin_written;
	logic [TIME_W-1:0]     compare_time;
	logic                  compare_written;
	logic                  gate_pulse_started;
	logic [TIME_W-1:0]     measured_half_period;
	logic [PHASE_W-1:0]    sync_phase;

	// predicted block state
	cfg_t               pr_cfg;
	logic [PHASE_W-1:0] pr_phase;
	logic [CNT_W-1:0]   pr_count;
	logic [TIME_W-1:0]  pr_last;
	logic [SUM_W-1:0]   pr_sum;
	logic [TIME_W-1:0]  pr_half;
	logic [TIME_W-1:0]  pr_delay;
	gate_stage_t        pr_gate;
	logic [TIME_W-1:0]  pr_sched;
	logic               pr_pin;

	result_t     pending_results [$];
	int unsigned mismatches;
	int unsigned items_sent;
	bit          calm;

	triac_phase_gate_timer u_dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_we               (cfg_we),
		.cfg_index            (cfg_index),
		.cfg_data             (cfg_data),
		.in_valid             (in_valid),
		.in_stall             (in_stall),
		.zero_cross_event     (zero_cross_event),
		.compare_event        (compare_event),
		.capture_time         (capture_time),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.pin_level            (pin_level),
		.pin_written          (pin_written),
		.compare_time         (compare_time),
		.compare_written      (compare_written),
		.gate_pulse_started   (gate_pulse_started),
		.measured_half_period (measured_half_period),
		.sync_phase           (sync_phase)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("triac_phase_gate_timer regression: fail");
		$finish;
	end

	function automatic result_t gate_timer_predict(input item_t ev);
		result_t           r;
		logic              pin_w;
		logic              cmp_w;
		logic              fired;
		logic [TIME_W-1:0] interval;
		logic [23:0]       scaled;
		pin_w = 1'b0;
		cmp_w = 1'b0;
		fired = 1'b0;
		if (ev.zero_cross_event) begin
			case (pr_phase)
				PHASE_SETTLE: begin
					pr_count = pr_count + 8'd1;
					if (pr_count == pr_cfg.settle_events) begin
						pr_count = '0;
						pr_phase = PHASE_FIRST;
					end
				end
				PHASE_FIRST: begin
					pr_last = ev.capture_time;
					pr_count = '0;
					pr_sum = '0;
					pr_phase = PHASE_MEASURE;
				end
				PHASE_MEASURE: begin
					interval = ev.capture_time - pr_last;
					pr_sum = pr_sum + {4'b0, interval};
					pr_last = ev.capture_time;
					pr_count = pr_count + 8'd1;
					if (pr_count == MEAS_CROSSINGS) begin
						pr_half = 16'(pr_sum / (2 * MEAS_CROSSINGS));
						scaled = pr_half * pr_cfg.usable_fraction;
						pr_delay = scaled[23:8];
						pr_phase = PHASE_ARM;
					end
				end
				PHASE_ARM: begin
					pr_last = ev.capture_time;
					pr_sched = ev.capture_time + pr_half - pr_cfg.pre_zero_offset;
					cmp_w = 1'b1;
					pr_gate = G_SAFE;
					pr_phase = PHASE_RUN;
				end
				PHASE_RUN: begin
					pr_last = ev.capture_time;
					pr_sched = ev.capture_time + pr_delay;
					cmp_w = 1'b1;
					pr_gate = G_FIRST_ON;
				end
				default: ;
			endcase
		end
		if (ev.compare_event && (pr_phase == PHASE_ARM || pr_phase == PHASE_RUN)) begin
			case (pr_gate)
				G_FIRST_ON, G_SECOND_ON: begin
					pr_pin = 1'b0;
					pin_w = 1'b1;
					fired = 1'b1;
					pr_sched = pr_sched + pr_cfg.gate_pulse_width;
					cmp_w = 1'b1;
					pr_gate = (pr_gate == G_FIRST_ON) ? G_FIRST_OFF : G_SECOND_OFF;
				end
				G_FIRST_OFF: begin
					pr_pin = 1'b1;
					pin_w = 1'b1;
					pr_sched = pr_last + pr_half + pr_delay;
					cmp_w = 1'b1;
					pr_gate = G_SECOND_ON;
				end
				// second turn-off leaves the compare value alone
				G_SECOND_OFF: begin
					pr_pin = 1'b1;
					pin_w = 1'b1;
					pr_gate = G_FIRST_ON;
				end
				G_SAFE: begin
					pr_pin = 1'b1;
					pin_w = 1'b1;
					pr_sched = pr_sched + pr_cfg.safe_release_delay;
					cmp_w = 1'b1;
					pr_gate = G_FIRST_OFF;
				end
				default: ;
			endcase
		end
		r.pin_level = pr_pin;
		r.pin_written = pin_w;
		r.compare_time = cmp_w ? pr_sched : '0;
		r.compare_written = cmp_w;
		r.gate_pulse_started = fired;
		r.measured_half_period = pr_half;
		r.sync_phase = pr_phase;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("%0t mismatch: %s", $realtime, msg);
	endtask

	task automatic check_field(input string label, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", label, got, want));
	endtask

	// result side: random stall, compare every accepted beat against the oldest expectation
	initial begin
		result_t want;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result beat with nothing expected");
				end else begin
					want = pending_results.pop_front();
					check_field("pin_level", 16'(pin_level), 16'(want.pin_level));
					check_field("pin_written", 16'(pin_written), 16'(want.pin_written));
					check_field("compare_time", compare_time, want.compare_time);
					check_field("compare_written", 16'(compare_written),
						16'(want.compare_written));
					check_field("gate_pulse_started", 16'(gate_pulse_started),
						16'(want.gate_pulse_started));
					check_field("measured_half_period", measured_half_period,
						want.measured_half_period);
					check_field("sync_phase", 16'(sync_phase), 16'(want.sync_phase));
				end
			end
			out_stall <= !calm && ($urandom_range(0, 99) < 19);
		end
	end

	task automatic send_event(input item_t ev, input bit typed, input result_t want);
		result_t predicted;
		calm = (items_sent >= 1000 && items_sent < 1300);
		while (!calm && $urandom_range(0, 99) < 19) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		zero_cross_event <= ev.zero_cross_event;
		compare_event <= ev.compare_event;
		capture_time <= ev.capture_time;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = gate_timer_predict(ev);
		pending_results.push_back(typed ? want : predicted);
		items_sent++;
	endtask

	task automatic load_config(input cfg_t c);
		// 8-bit registers take the low byte, so the upper byte is noise
		cfg_we <= 1'b1;
		cfg_index <= CFG_SETTLE_EVENTS;
		cfg_data <= {8'($urandom), c.settle_events};
		@(posedge clk);
		cfg_index <= CFG_PULSE_WIDTH;
		cfg_data <= c.gate_pulse_width;
		@(posedge clk);
		cfg_index <= CFG_PRE_ZERO;
		cfg_data <= c.pre_zero_offset;
		@(posedge clk);
		cfg_index <= CFG_SAFE_DELAY;
		cfg_data <= c.safe_release_delay;
		@(posedge clk);
		cfg_index <= CFG_FRACTION;
		cfg_data <= {8'($urandom), c.usable_fraction};
		@(posedge clk);
		cfg_we <= 1'b0;
		pr_cfg = c;
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// mostly whole line half-cycles: crossing then the gate compares, plus some noise
	task automatic line_traffic(input int unsigned n_items);
		int unsigned first;
		int unsigned line_half;
		int unsigned n_cmp;
		logic [TIME_W-1:0] line_t;
		item_t ev;
		first = items_sent;
		line_half = $urandom_range(150, 30000);
		line_t = 16'($urandom);
		while (items_sent - first < n_items) begin
			if ($urandom_range(0, 99) < 75) begin
				line_t = line_t + 16'(line_half) + 16'($urandom_range(0, 64)) - 16'd32;
				ev = '{1'b1, $urandom_range(0, 9) == 0, line_t};
				send_event(ev, 1'b0, '0);
				n_cmp = ($urandom_range(0, 9) < 7) ? 4 : $urandom_range(1, 6);
				repeat (n_cmp) begin
					ev = '{1'b0, 1'b1, 16'($urandom)};
					send_event(ev, 1'b0, '0);
				end
			end else begin
				ev = '{1'($urandom), 1'($urandom), 16'($urandom)};
				send_event(ev, 1'b0, '0);
			end
		end
	endtask

	initial begin
		item_t ev;
		cfg_t  phase_cfg [5];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_SETTLE_EVENTS;
		cfg_data = '0;
		in_valid = 1'b0;
		zero_cross_event = 1'b0;
		compare_event = 1'b0;
		capture_time = '0;
		mismatches = 0;
		items_sent = 0;
		calm = 1'b0;
		pr_cfg = '{SETTLE_RST, PULSE_WIDTH_RST, PRE_ZERO_RST, SAFE_DELAY_RST, FRACTION_RST};
		pr_phase = PHASE_SETTLE;
		pr_count = '0;
		pr_last = '0;
		pr_sum = '0;
		pr_half = '0;
		pr_delay = GATE_DELAY_RST;
		pr_gate = G_SAFE;
		pr_sched = '0;
		pr_pin = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_config('{8'd0, 16'hFFFF, 16'h0000, 16'hFFFF, 8'd255});
		for (int r = 0; r < 25; r++) begin
			for (int k = 0; k < SCRIPT[r].reps; k++) begin
				ev = '{SCRIPT[r].zc, SCRIPT[r].cmp, SCRIPT[r].cap};
				send_event(ev, SCRIPT[r].typed, SCRIPT[r].want);
			end
		end

		phase_cfg[0] = '{8'd255, 16'h0000, 16'hFFFF, 16'h0000, 8'd0};
		phase_cfg[1] = '{SETTLE_RST, PULSE_WIDTH_RST, PRE_ZERO_RST, SAFE_DELAY_RST,
			FRACTION_RST};
		phase_cfg[2] = '{8'($urandom_range(1, 255)), 16'($urandom), 16'($urandom),
			16'($urandom), 8'($urandom)};
		phase_cfg[3] = '{8'd1, 16'hFFFF, 16'h0000, 16'hFFFF, 8'd255};
		phase_cfg[4] = '{8'($urandom_range(1, 255)), 16'($urandom_range(0, 3000)),
			16'($urandom), 16'($urandom), 8'($urandom)};
		for (int p = 0; p < 5; p++) begin
			wait_idle();
			load_config(phase_cfg[p]);
			line_traffic(PHASE_ITEMS);
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("triac_phase_gate_timer regression: pass");
		else
			$display("triac_phase_gate_timer regression: fail");
		$finish;
	end

endmodule

[triac_phase_gate_timer.f]
rtl/tpgt_pkg.sv
rtl/tpgt_cfg.sv
rtl/tpgt_engine.sv
rtl/triac_phase_gate_timer.sv
tb/sv/tb.sv
